// ===== rtl/core/b2da_pkg.sv =====
// Shared constants, types and conversion helpers for the binary to decimal ASCII block.
// Used by every module of the block; depends on nothing else.
package b2da_pkg;

	localparam int ValueWidth   = 64;
	localparam int NumDigits    = 20;
	localparam int DigitWidth   = 4;
	localparam int BcdWidth     = NumDigits * DigitWidth;
	localparam int CountWidth   = $clog2(NumDigits + 1);
	localparam int BitsPerStep  = 4;
	localparam int StepCount    = ValueWidth / BitsPerStep;
	localparam int StepCntWidth = $clog2(StepCount);
	localparam int QueueDepth   = 2;
	localparam int QueuePtrWidth = $clog2(QueueDepth);
	localparam int QueueCntWidth = $clog2(QueueDepth + 1);

	// ASCII '0' is 6'b110000, so a digit character is the digit below these two bits.
	localparam logic [1:0] AsciiHigh = 2'b11;
	localparam logic [DigitWidth-1:0] DigitMax    = 4'd9;
	localparam logic [DigitWidth-1:0] DabbleLimit = 4'd5;
	localparam logic [DigitWidth-1:0] DabbleAdd   = 4'd3;

	typedef logic [DigitWidth-1:0] digit_t;
	typedef digit_t [NumDigits-1:0] bcd_t;

	// One converted word on its way from the front to the back.
	typedef struct packed {
		bcd_t                  bcd;
		logic [CountWidth-1:0] ndig;
	} conv_t;

	typedef enum logic [1:0] {
		FRONT_IDLE,
		FRONT_CONV,
		FRONT_PUSH
	} front_state_t;

	// One shift-add-3 step: correct every digit of five or more, then shift one bit in.
	function automatic bcd_t dabble_bit(input bcd_t b, input logic in_bit);
		bcd_t                r;
		logic [BcdWidth-1:0] f;
		r = b;
		for (int i = 0; i < NumDigits; i++) begin
			if (r[i] >= DabbleLimit) begin
				r[i] = r[i] + DabbleAdd;
			end
		end
		f = r;
		f = {f[BcdWidth-2:0], in_bit};
		return f;
	endfunction

	// Number of significant digits, at least one.
	function automatic logic [CountWidth-1:0] digit_count(input bcd_t b);
		logic [CountWidth-1:0] n;
		n = CountWidth'(1);
		for (int i = 0; i < NumDigits; i++) begin
			if (b[i] != '0) begin
				n = CountWidth'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

// ===== rtl/core/b2da_front.sv =====
// Front end: accepts a binary word and converts it to packed BCD, four bits a cycle.
// Depends on b2da_pkg.
module b2da_front import b2da_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [ValueWidth-1:0] value,
	input  logic                  push,
	output logic                  full,
	output conv_t                 q_data,
	output logic                  q_push,
	input  logic                  q_full
);

	front_state_t            state_q, state_d;
	logic [ValueWidth-1:0]   bin_q;
	bcd_t                    bcd_q;
	bcd_t                    bcd_next;
	logic [StepCntWidth-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FRONT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_push  = 1'b0;
		case (state_q)
			FRONT_IDLE: begin
				if (push) begin
					state_d = FRONT_CONV;
				end
			end
			FRONT_CONV: begin
				if (cnt_q == StepCntWidth'(StepCount - 1)) begin
					state_d = FRONT_PUSH;
				end
			end
			FRONT_PUSH: begin
				q_push = !q_full;
				if (!q_full) begin
					state_d = FRONT_IDLE;
				end
			end
			default: begin
				state_d = FRONT_IDLE;
			end
		endcase
	end

	// Four dependent dabble steps per cycle, most significant input bits first.
	always_comb begin
		bcd_next = bcd_q;
		for (int k = 0; k < BitsPerStep; k++) begin
			bcd_next = dabble_bit(bcd_next, bin_q[ValueWidth-1-k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == FRONT_CONV) begin
			cnt_q <= cnt_q + StepCntWidth'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FRONT_IDLE && push) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (state_q == FRONT_CONV) begin
			bin_q <= bin_q << BitsPerStep;
			bcd_q <= bcd_next;
		end
	end

	assign full        = (state_q != FRONT_IDLE);
	assign q_data.bcd  = bcd_q;
	assign q_data.ndig = digit_count(bcd_q);

	// Every input bit has been shifted into the BCD register by the time the word is offered.
	a_bin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FRONT_PUSH |-> bin_q == '0)
		else $error("front offers a word before all input bits were converted");

endmodule

// ===== rtl/core/b2da_fifo.sv =====
// Short queue of converted words between the front and the back.
// Depends on b2da_pkg.
module b2da_fifo import b2da_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  conv_t wr_data,
	input  logic  wr_push,
	output logic  wr_full,
	output conv_t rd_data,
	input  logic  rd_pop,
	output logic  rd_empty
);

	conv_t                    mem_q [QueueDepth];
	logic [QueuePtrWidth-1:0] wr_ptr_q;
	logic [QueuePtrWidth-1:0] rd_ptr_q;
	logic [QueueCntWidth-1:0] cnt_q;

	assign wr_full  = (cnt_q == QueueCntWidth'(QueueDepth));
	assign rd_empty = (cnt_q == '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_push) begin
				wr_ptr_q <= wr_ptr_q + QueuePtrWidth'(1);
			end
			if (rd_pop) begin
				rd_ptr_q <= rd_ptr_q + QueuePtrWidth'(1);
			end
			if (wr_push && !rd_pop) begin
				cnt_q <= cnt_q + QueueCntWidth'(1);
			end else if (rd_pop && !wr_push) begin
				cnt_q <= cnt_q - QueueCntWidth'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_push |-> !wr_full)
		else $error("front pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pop |-> !rd_empty)
		else $error("back popped an empty queue");

endmodule

// ===== rtl/core/b2da_back.sv =====
// Back end: walks one converted word from its top digit down and emits ASCII digits.
// Depends on b2da_pkg.
module b2da_back import b2da_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  conv_t      q_data,
	input  logic       q_empty,
	output logic       q_pop,
	output logic [5:0] digit_char,
	output logic       last_digit,
	output logic       empty,
	input  logic       pop
);

	logic                  busy_q;
	bcd_t                  bcd_q;
	logic [CountWidth-1:0] idx_q;
	logic                  out_valid_q;
	digit_t                digit_q;
	logic                  last_q;
	logic                  emit;

	assign q_pop = !busy_q && !q_empty;
	assign emit  = busy_q && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= q_data.ndig - CountWidth'(1);
			end else if (emit) begin
				if (idx_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q - CountWidth'(1);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			bcd_q <= q_data.bcd;
		end
		if (emit) begin
			digit_q <= bcd_q[idx_q];
			last_q  <= (idx_q == '0);
		end
	end

	assign empty      = !out_valid_q;
	assign digit_char = {AsciiHigh, digit_q};
	assign last_digit = last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < CountWidth'(NumDigits))
		else $error("digit index beyond the BCD word");

	a_digit_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> digit_q <= DigitMax)
		else $error("non-decimal digit on the result ports");

endmodule

// ===== rtl/core/binary_to_decimal_ascii_top.sv =====
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_front, b2da_fifo and b2da_back.

// Each 64-bit unsigned word pushed in comes out as its decimal digits in ASCII, most
// significant first, with leading zeros dropped, so zero gives the single digit '0'. A run
// holds 1 to 20 digits and last_digit marks its final, least significant digit. Both sides
// look like a queue: a word is taken when push is high and full is low, and a digit is
// taken when pop is high and empty is low. The front converts a word to BCD with the
// shift-add-3 method, four input bits per cycle. After taking a word it holds full high
// while it converts and while it hands the result to the two-entry queue, and longer
// while that queue is full, so it takes no new word before the last one is handed on.
// The back loads a word from the queue and then delivers one digit per cycle while the
// consumer pops; it loads the next word only once it has emitted the last digit of the
// current one. The two run concurrently, so the sustained rate is set by the slower of
// the two. The oldest digit is held in an output register, so the front keeps converting
// while a result waits. The block keeps nothing from one word to the next.
module binary_to_decimal_ascii_top import b2da_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [ValueWidth-1:0] value,
	input  logic                  push,
	output logic                  full,
	output logic [5:0]            digit_char,
	output logic                  last_digit,
	output logic                  empty,
	input  logic                  pop
);

	conv_t fq_data;
	conv_t qb_data;
	logic  fq_push;
	logic  fq_full;
	logic  qb_pop;
	logic  qb_empty;

	// Front: takes the word and produces its BCD form and digit count.
	b2da_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (value),
		.push   (push),
		.full   (full),
		.q_data (fq_data),
		.q_push (fq_push),
		.q_full (fq_full)
	);

	// Queue: lets the front start the next word while the back is still emitting.
	b2da_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (fq_data),
		.wr_push  (fq_push),
		.wr_full  (fq_full),
		.rd_data  (qb_data),
		.rd_pop   (qb_pop),
		.rd_empty (qb_empty)
	);

	// Back: walks the digits from the most significant one down to the output register.
	b2da_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (qb_data),
		.q_empty    (qb_empty),
		.q_pop      (qb_pop),
		.digit_char (digit_char),
		.last_digit (last_digit),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

// ===== tb/tb_binary_to_decimal_ascii_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for binary_to_decimal_ascii_top: pushes 64-bit words and checks each
// ASCII digit that comes out against digits worked out here. Depends on b2da_pkg and the RTL.
module tb_binary_to_decimal_ascii_top;
	import b2da_pkg::*;

	localparam int         ClkPeriod   = 10;
	localparam int         ResetCycles = 7;
	localparam int         MaxGap      = 4;
	// Long enough for the block to fill up completely and hold full high for a good while.
	localparam int         HoldCycles  = 300;
	// Long enough for the front and the back to finish any word, so this covers any stragglers.
	localparam int         DrainCycles = 64;
	localparam logic [5:0] AsciiZero   = 6'd48;
	localparam logic [ValueWidth-1:0] DecBase = 64'd10;

	// One digit as it should appear on the result ports.
	typedef struct packed {
		logic [5:0] ch;
		logic       last;
	} digit_word_t;

	logic                  clk;
	logic                  arst_n;
	logic [ValueWidth-1:0] value;
	logic                  push;
	logic                  full;
	logic [5:0]            digit_char;
	logic                  last_digit;
	logic                  empty;
	logic                  pop;

	// Digits still owed by the block, oldest first.
	digit_word_t expected_digits[$];
	int          fail_count = 0;

	// The sender draws random gaps while tx_gap_on is set; the receiver draws random stalls
	// while rx_stall_on is set. rx_hold keeps pop low for a long stretch on request.
	bit          tx_gap_on   = 1'b1;
	bit          rx_stall_on = 1'b1;
	logic        rx_hold;
	event        hold_request;

	binary_to_decimal_ascii_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.push       (push),
		.full       (full),
		.digit_char (digit_char),
		.last_digit (last_digit),
		.empty      (empty),
		.pop        (pop)
	);

	initial begin
		clk = 1'b0;
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	// Splits a word into decimal digits by repeated division, least significant first, then
	// queues them most significant first. The final digit queued carries the last flag.
	function automatic void predict_decimal_digits(input logic [ValueWidth-1:0] v);
		logic [3:0]            rev[NumDigits];
		logic [ValueWidth-1:0] rest;
		int                    n;
		digit_word_t           w;
		rest = v;
		n = 0;
		do begin
			rev[n] = 4'(rest % DecBase);
			rest = rest / DecBase;
			n++;
		end while (rest != '0 && n < NumDigits);
		for (int k = n - 1; k >= 0; k--) begin
			w.ch = AsciiZero + 6'(rev[k]);
			w.last = (k == 0);
			expected_digits.push_back(w);
		end
	endfunction

	// Random words spread over every digit count: full-width values, values shifted down
	// by a random amount, and values right at a power of ten or one either side of it.
	function automatic logic [ValueWidth-1:0] random_value();
		logic [ValueWidth-1:0] r;
		logic [ValueWidth-1:0] p;
		int                    sel;
		int                    k;
		r = {$urandom, $urandom};
		sel = $urandom_range(0, 3);
		if (sel == 0) begin
			return r;
		end else if (sel < 3) begin
			return r >> $urandom_range(0, ValueWidth - 1);
		end
		p = 64'd1;
		k = $urandom_range(1, 19);
		repeat (k) p = p * DecBase;
		case ($urandom_range(0, 2))
			0: begin
				return p - 64'd1;
			end
			1: begin
				return p;
			end
			default: begin
				return p + 64'd1;
			end
		endcase
	endfunction

	// Offers one word after a random gap, during which value carries junk that the block
	// must ignore, and returns in the time step in which the word is taken. push is left
	// high so that back-to-back words follow without push dropping in between.
	task automatic send_word(input logic [ValueWidth-1:0] v);
		int gap;
		gap = tx_gap_on ? $urandom_range(0, MaxGap) : 0;
		repeat (gap) begin
			push <= 1'b0;
			value <= {$urandom, $urandom};
			@(posedge clk);
		end
		push <= 1'b1;
		value <= v;
		do begin
			@(posedge clk);
		end while (full);
		predict_decimal_digits(v);
	endtask

	// Drops push and waits for the next clock edge, so that the next send never drives push twice
	// in one time step.
	task automatic stop_sending();
		push <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_for_all_digits();
		while (expected_digits.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Receiver and checker. Outputs are sampled at the rising edge, so they are the values
	// the block presented during the cycle that is ending. After each digit it takes, the
	// receiver draws a stall; a pending hold-off keeps pop low regardless.
	initial begin : digit_checker
		int          stall;
		digit_word_t want;
		pop = 1'b0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (expected_digits.size() == 0) begin
					$error("digit_char: expected no digit, actual %0d", digit_char);
					fail_count++;
				end else begin
					want = expected_digits.pop_front();
					if (digit_char !== want.ch) begin
						$error("digit_char: expected %0d, actual %0d", want.ch, digit_char);
						fail_count++;
					end
					if (last_digit !== want.last) begin
						$error("last_digit: expected %0d, actual %0d", want.last, last_digit);
						fail_count++;
					end
				end
				stall = rx_stall_on ? $urandom_range(0, MaxGap) : 0;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= arst_n && !rx_hold;
			end
		end
	end

	// Long receiver hold-off, counted here so the sender can keep offering words meanwhile.
	initial begin : receiver_hold
		rx_hold = 1'b0;
		forever begin
			@(hold_request);
			rx_hold <= 1'b1;
			repeat (HoldCycles) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	// Extremes and boundaries: zero gives a lone '0', the largest word gives the full
	// twenty digits, and most of the rest sit on digit-count and bit-width boundaries. Zero
	// and the largest word between them set and clear every input bit.
	task automatic test_directed_values();
		logic [ValueWidth-1:0] vals[17];
		vals = '{
			64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd999999,
			64'hFFFF_FFFF, 64'h1_0000_0000,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
			64'd9999999999999999999, 64'd10000000000000000000,
			64'd12345678901234567890,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			64'hFFFF_FFFF_FFFF_FFFF
		};
		foreach (vals[i]) begin
			send_word(vals[i]);
		end
		stop_sending();
	endtask

	// The bulk of the run, with random gaps and stalls on both sides.
	task automatic test_random_values();
		repeat (250) begin
			send_word(random_value());
		end
		stop_sending();
	endtask

	// The receiver stops for a long stretch while the sender pushes without gaps, so the
	// block fills up and raises full until the receiver resumes.
	task automatic test_full_stall();
		tx_gap_on = 1'b0;
		->hold_request;
		repeat (20) begin
			send_word(random_value());
		end
		stop_sending();
		tx_gap_on = 1'b1;
	endtask

	// No idling on either side, to run the block at its full rate.
	task automatic test_streaming();
		tx_gap_on = 1'b0;
		rx_stall_on <= 1'b0;
		repeat (40) begin
			send_word(random_value());
		end
		stop_sending();
		wait_for_all_digits();
		tx_gap_on = 1'b1;
		rx_stall_on <= 1'b1;
	endtask

	// Short bursts, each started only once the block has delivered every digit so far,
	// so that a word also arrives at a completely idle block.
	task automatic test_sender_pause();
		repeat (4) begin
			repeat (10) begin
				send_word(random_value());
			end
			stop_sending();
			wait_for_all_digits();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		value = '0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_values();
		test_random_values();
		test_full_stall();
		test_streaming();
		test_sender_pause();
		wait_for_all_digits();
		// Any digit the block still sends now is caught as unexpected by the checker.
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Timeout, several times longer than the slowest correct run.
	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/b2da_pkg.sv
rtl/core/b2da_front.sv
rtl/core/b2da_fifo.sv
rtl/core/b2da_back.sv
rtl/core/binary_to_decimal_ascii_top.sv
tb/tb_binary_to_decimal_ascii_top.sv
